>>> rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: transfer payload types,
// controller/datapath command and status structs, and decode constants.
// No dependencies.
package u8u16_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       message_end;
	} byte_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        replaced;
		logic        run_last;
		logic        final_unit;
	} unit_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // take a byte into the buffer
		logic step;   // resolve the sequence at the buffer front
		logic low;    // move the low surrogate into the hold slot
		logic flush;  // close the byte: hold slot out with run_last
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;       // nothing more to resolve for this byte
		logic emits;      // front sequence produces a unit
		logic surrogate;  // front sequence produces a surrogate pair
		logic hold_v;     // hold slot occupied
		logic push_ok;    // output register can take a unit
	} ctl_sts_t;

	localparam int BUF_DEPTH = 4;
	localparam int CNT_W     = 3;

	localparam logic [0:0] REG_KEEP_BOM = 1'b0;

	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [20:0] BOM_CP      = 21'h00FEFF;
	localparam logic [20:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0] HI_BASE     = 16'hD800;
	localparam logic [15:0] LO_BASE     = 16'hDC00;

	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [7:0] L2_MIN    = 8'hC2;
	localparam logic [7:0] L2_MAX    = 8'hDF;
	localparam logic [7:0] L3_MIN    = 8'hE0;
	localparam logic [7:0] L3_MAX    = 8'hEF;
	localparam logic [7:0] L4_MIN    = 8'hF0;
	localparam logic [7:0] L4_MAX    = 8'hF4;
	localparam logic [7:0] E0_LEAD   = 8'hE0;
	localparam logic [7:0] E0_MIN    = 8'hA0;
	localparam logic [7:0] ED_LEAD   = 8'hED;
	localparam logic [7:0] ED_MAX    = 8'h9F;
	localparam logic [7:0] F0_LEAD   = 8'hF0;
	localparam logic [7:0] F0_MIN    = 8'h90;
	localparam logic [7:0] F4_LEAD   = 8'hF4;
	localparam logic [7:0] F4_MAX    = 8'h8F;

endpackage

>>> rtl/utf8_lossy_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 decoder with replacement: one byte per input transfer.
// A byte is loaded; each sequence is resolved into the hold slot, one step per
// cycle unless the output stalls, a surrogate pair taking a further low step; a
// held unit moves to the output on the next step or on the flush closing the byte.
// Until then byte_stall is high. A byte awaiting continuation bytes is not stepped.
// Reset: arst_n clears buffer count, hold and output valid, keep_bom to 0.
module utf8_lossy_to_utf16_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  u8u16_pkg::byte_t  byte_data,
	output logic              unit_valid,
	input  logic              unit_stall,
	output u8u16_pkg::unit_t  unit_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import u8u16_pkg::*;

	logic     keep_bom;
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	u8u16_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.keep_bom (keep_bom)
	);

	u8u16_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	u8u16_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.keep_bom   (keep_bom),
		.byte_data  (byte_data),
		.unit_stall (unit_stall),
		.unit_valid (unit_valid),
		.unit_data  (unit_data),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> rtl/u8u16_regs.sv
// Configuration register file (keep_bom) behind an APB-style port.
// Depends on u8u16_pkg.
module u8u16_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        keep_bom
);
	import u8u16_pkg::*;

	logic keep_bom_q;
	logic sel_keep_bom;

	assign pready       = 1'b1;
	assign sel_keep_bom = (paddr[2] == REG_KEEP_BOM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_bom_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && sel_keep_bom) begin
			keep_bom_q <= pwdata[0];
		end
	end

	assign prdata   = sel_keep_bom ? {31'd0, keep_bom_q} : 32'd0;
	assign keep_bom = keep_bom_q;

endmodule

>>> rtl/u8u16_dp.sv
// Decoder datapath: pending byte buffer, sequence decode, surrogate split,
// hold slot and output register. Depends on u8u16_pkg.
module u8u16_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                keep_bom,
	input  u8u16_pkg::byte_t    byte_data,
	input  logic                unit_stall,
	output logic                unit_valid,
	output u8u16_pkg::unit_t    unit_data,
	input  u8u16_pkg::ctl_cmd_t cmd,
	output u8u16_pkg::ctl_sts_t sts
);
	import u8u16_pkg::*;

	logic [7:0]       buf_q [BUF_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic             end_q;
	logic             start_q;
	logic [15:0]      hold_unit_q;
	logic             hold_rep_q;
	logic             hold_v_q;
	logic [15:0]      lo_q;
	unit_t            out_q;
	logic             out_v_q;

	logic [7:0]       b0, b1, b2, b3;
	logic             c1, c2, c3;
	logic [CNT_W-1:0] need;
	logic             short_seq;
	logic             ok;
	logic             ok_eff;
	logic [20:0]      cp;
	logic [20:0]      cp_eff;
	logic [20:0]      v_w;
	logic [CNT_W-1:0] consume;
	logic             bom_skip;
	logic             surrogate;
	logic [15:0]      hi_unit;
	logic [15:0]      lo_unit;
	logic             push;

	assign b0 = buf_q[0];
	assign b1 = buf_q[1];
	assign b2 = buf_q[2];
	assign b3 = buf_q[3];
	assign c1 = (b1[7:6] == 2'b10);
	assign c2 = (b2[7:6] == 2'b10);
	assign c3 = (b3[7:6] == 2'b10);

	always_comb begin
		if (b0 < ASCII_END) begin
			need = 3'd1;
		end else if (b0 >= L2_MIN && b0 <= L2_MAX) begin
			need = 3'd2;
		end else if (b0 >= L3_MIN && b0 <= L3_MAX) begin
			need = 3'd3;
		end else if (b0 >= L4_MIN && b0 <= L4_MAX) begin
			need = 3'd4;
		end else begin
			need = 3'd1;
		end
	end

	always_comb begin
		case (need)
			3'd1: begin
				ok = (b0 < ASCII_END);
				cp = {13'd0, b0};
			end
			3'd2: begin
				ok = c1;
				cp = {10'd0, b0[4:0], b1[5:0]};
			end
			3'd3: begin
				ok = c1 && c2 && !(b0 == E0_LEAD && b1 < E0_MIN)
					&& !(b0 == ED_LEAD && b1 > ED_MAX);
				cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			end
			3'd4: begin
				ok = c1 && c2 && c3 && !(b0 == F0_LEAD && b1 < F0_MIN)
					&& !(b0 == F4_LEAD && b1 > F4_MAX);
				cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			end
			default: begin
				ok = 1'b0;
				cp = 21'd0;
			end
		endcase
	end

	// truncated at message end: lead alone becomes a replacement
	assign short_seq = (cnt_q < need);
	assign ok_eff    = ok && !short_seq;
	assign cp_eff    = ok_eff ? cp : {5'd0, REPLACEMENT};
	assign consume   = ok_eff ? need : 3'd1;
	assign bom_skip  = ok_eff && start_q && (need == 3'd3) && (cp == BOM_CP) && !keep_bom;
	assign surrogate = ok_eff && (cp[20:16] != 5'd0);
	assign v_w       = cp_eff - SUPP_BASE;
	assign hi_unit   = HI_BASE + {6'd0, v_w[19:10]};
	assign lo_unit   = LO_BASE + {6'd0, v_w[9:0]};

	assign sts.done      = (cnt_q == 3'd0) || (short_seq && !end_q);
	assign sts.emits     = !bom_skip;
	assign sts.surrogate = surrogate;
	assign sts.hold_v    = hold_v_q;
	assign sts.push_ok   = !out_v_q || !unit_stall;

	assign push = (cmd.step && !bom_skip && hold_v_q) || cmd.low || (cmd.flush && hold_v_q);

	// pending bytes: payload only, bytes past cnt_q are not used
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= byte_data.in_byte;
		end else if (cmd.step) begin
			case (consume)
				3'd1: begin
					buf_q[0] <= buf_q[1];
					buf_q[1] <= buf_q[2];
					buf_q[2] <= buf_q[3];
				end
				3'd2: begin
					buf_q[0] <= buf_q[2];
					buf_q[1] <= buf_q[3];
				end
				3'd3: begin
					buf_q[0] <= buf_q[3];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			end_q    <= 1'b0;
			start_q  <= 1'b1;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= cnt_q + 3'd1;
				end_q <= byte_data.message_end;
			end else if (cmd.step) begin
				cnt_q   <= cnt_q - consume;
				start_q <= 1'b0;
			end else if (cmd.flush && end_q) begin
				cnt_q   <= '0;
				start_q <= 1'b1;
			end

			if (cmd.step && !bom_skip) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end

			if (push) begin
				out_v_q <= 1'b1;
			end else if (!unit_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && !bom_skip) begin
			hold_unit_q <= surrogate ? hi_unit : cp_eff[15:0];
			hold_rep_q  <= !ok_eff;
			lo_q        <= lo_unit;
		end else if (cmd.low) begin
			hold_unit_q <= lo_q;
			hold_rep_q  <= 1'b0;
		end
		if (push) begin
			out_q.code_unit  <= hold_unit_q;
			out_q.replaced   <= hold_rep_q;
			out_q.run_last   <= cmd.flush;
			out_q.final_unit <= cmd.flush && end_q;
		end
	end

	assign unit_valid = out_v_q;
	assign unit_data  = out_q;

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> cnt_q <= 3'd3)
		else $error("byte loaded into a full buffer");

	a_low_has_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.low |-> hold_v_q && sts.push_ok)
		else $error("low surrogate issued without hold slot or output room");

	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !bom_skip && hold_v_q) |-> sts.push_ok)
		else $error("unit pushed into a busy output register");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.flush && end_q) |=> (cnt_q == 3'd0) && start_q && !hold_v_q)
		else $error("message end left pending state");

endmodule

>>> rtl/u8u16_ctrl.sv
// Decoder controller: accepts a byte, then steps the datapath through the
// buffered sequences and closes the byte. Depends on u8u16_pkg.
module u8u16_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u8u16_pkg::ctl_sts_t sts,
	output u8u16_pkg::ctl_cmd_t cmd
);
	import u8u16_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOW
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = byte_valid;
			end
			ST_SCAN: begin
				if (sts.done) begin
					cmd.flush = !sts.hold_v || sts.push_ok;
				end else begin
					cmd.step = !sts.emits || !sts.hold_v || sts.push_ok;
				end
			end
			ST_LOW: begin
				cmd.low = sts.push_ok;
			end
			default: begin
			end
		endcase
	end

	assign byte_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.flush) begin
						state_q <= ST_IDLE;
					end else if (cmd.step && sts.emits && sts.surrogate) begin
						state_q <= ST_LOW;
					end
				end
				ST_LOW: begin
					if (cmd.low) state_q <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> dv/utf8_lossy_to_utf16_decoder_unit_tb.sv
// Self-checking testbench for utf8_lossy_to_utf16_decoder_unit: directed and random UTF-8
// messages and an in-bench predictor of the UTF-16 units, with or without random idling.
// Depends on rtl/u8u16_pkg.sv and rtl/utf8_lossy_to_utf16_decoder_unit.sv.
`timescale 1ns / 1ps

module utf8_lossy_to_utf16_decoder_unit_tb;

	localparam logic [2:0]  ADDR_KEEP_BOM = {u8u16_pkg::REG_KEEP_BOM, 2'b00};
	localparam logic [20:0] CP_FFFD       = 21'h00FFFD;
	localparam logic [20:0] CP_BOM        = 21'h00FEFF;
	localparam logic [20:0] CP_SUPP       = 21'h010000;
	localparam logic [15:0] HI_SURR       = 16'hD800;
	localparam logic [15:0] LO_SURR       = 16'hDC00;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_stall;
	u8u16_pkg::byte_t     byte_data;
	logic                 unit_valid;
	logic                 unit_stall;
	u8u16_pkg::unit_t     unit_data;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// predictor state
	logic [7:0]           pend [0:2];
	int                   pend_cnt;
	logic                 at_start;
	logic                 keep_bom_q;
	u8u16_pkg::unit_t     unit_q[$];

	logic [7:0]           msg_q[$];
	logic                 tx_idle;
	logic                 rx_idle;
	int                   stall_left;
	int                   errors;
	int                   bytes_sent;
	int                   msgs_sent;
	int                   units_seen;
	int                   reps_seen;

	utf8_lossy_to_utf16_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	function automatic logic is_cont(logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic int lead_len(logic [7:0] b);
		if (b < 8'h80) return 1;
		if (b >= 8'hC2 && b <= 8'hDF) return 2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3;
		if (b >= 8'hF0 && b <= 8'hF4) return 4;
		return 1;
	endfunction

	function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input int len, output logic ok);
		ok = 1'b0;
		if (len == 1) begin
			if (b0 < 8'h80) begin
				ok = 1'b1;
				return {13'd0, b0};
			end
			return CP_FFFD;
		end
		if (len == 2) begin
			if (!is_cont(b1)) return CP_FFFD;
			ok = 1'b1;
			return {10'd0, b0[4:0], b1[5:0]};
		end
		if (len == 3) begin
			if (!is_cont(b1) || !is_cont(b2)) return CP_FFFD;
			if (b0 == 8'hE0 && b1 < 8'hA0) return CP_FFFD;
			if (b0 == 8'hED && b1 > 8'h9F) return CP_FFFD;
			ok = 1'b1;
			return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
		end
		if (!is_cont(b1) || !is_cont(b2) || !is_cont(b3)) return CP_FFFD;
		if (b0 == 8'hF0 && b1 < 8'h90) return CP_FFFD;
		if (b0 == 8'hF4 && b1 > 8'h8F) return CP_FFFD;
		ok = 1'b1;
		return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
	endfunction

	task automatic predict_units(input logic [7:0] b, input logic e);
		logic [7:0]       bq [0:7];
		u8u16_pkg::unit_t res [0:3];
		logic [20:0]      cp;
		logic [20:0]      v;
		logic             ok;
		logic             first;
		int               n;
		int               pos;
		int               cnt;
		int               need;
		int               k;
		for (k = 0; k < 8; k++) bq[k] = 8'h00;
		n = pend_cnt;
		for (k = 0; k < n; k++) bq[k] = pend[k];
		bq[n] = b;
		n++;
		pos = 0;
		cnt = 0;
		while (pos < n) begin
			need = lead_len(bq[pos]);
			first = at_start;
			ok = 1'b0;
			if (n - pos < need) begin
				if (!e) break;
				cp = CP_FFFD;
				pos++;
			end else begin
				cp = decode_cp(bq[pos], bq[pos+1], bq[pos+2], bq[pos+3], need, ok);
				pos += ok ? need : 1;
			end
			at_start = 1'b0;
			if (ok && first && need == 3 && cp == CP_BOM && !keep_bom_q) continue;
			if (cp > 21'h00FFFF) begin
				v = cp - CP_SUPP;
				res[cnt] = {HI_SURR + {6'd0, v[19:10]}, 3'b000};
				cnt++;
				res[cnt] = {LO_SURR + {6'd0, v[9:0]}, 3'b000};
				cnt++;
			end else begin
				res[cnt] = {cp[15:0], !ok, 2'b00};
				cnt++;
			end
		end
		if (e) begin
			pend_cnt = 0;
			at_start = 1'b1;
		end else begin
			for (k = 0; k < n - pos; k++) pend[k] = bq[pos+k];
			pend_cnt = n - pos;
		end
		for (k = 0; k < cnt; k++) begin
			res[k].run_last = (k == cnt - 1);
			res[k].final_unit = (k == cnt - 1) && e;
			unit_q = {unit_q, res[k]};
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e);
		int gap;
		@(negedge clk);
		if (tx_idle && $urandom_range(5, 0) == 0) begin
			gap = $urandom_range(14, 1);
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= {b, e};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		predict_units(b, e);
		bytes_sent++;
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
		msgs_sent++;
	endtask

	// drain: sender holds off until every expected unit is back
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (unit_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(input logic val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_KEEP_BOM;
		pwdata <= {31'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		keep_bom_q = val;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[0] !== keep_bom_q) begin
			$error("keep_bom readback: expected %0b, actual %0b", keep_bom_q, prdata[0]);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic append_byte(input logic [7:0] b);
		msg_q = {msg_q, b};
	endtask

	task automatic put_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			append_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			append_byte({3'b110, cp[10:6]});
			append_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			append_byte({4'b1110, cp[15:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end else begin
			append_byte({5'b11110, cp[20:18]});
			append_byte({2'b10, cp[17:12]});
			append_byte({2'b10, cp[11:6]});
			append_byte({2'b10, cp[5:0]});
		end
	endtask

	function automatic logic [20:0] rand_multibyte_cp(int len);
		if (len == 2) return 21'($urandom_range(32'h7FF, 32'h80));
		if (len == 3) return 21'($urandom_range(32'hFFFF, 32'h800));
		return 21'($urandom_range(32'h10FFFF, 32'h10000));
	endfunction

	task automatic build_random_message();
		int nseq;
		int s;
		int kind;
		msg_q.delete();
		if ($urandom_range(3, 0) == 0) begin
			append_byte(8'hEF);
			append_byte(8'hBB);
			append_byte(8'hBF);
		end
		nseq = $urandom_range(6, 1);
		for (s = 0; s < nseq; s++) begin
			kind = $urandom_range(9, 0);
			case (kind)
				0, 1, 2: begin
					append_byte(8'($urandom_range(127, 0)));
				end
				3, 4, 5: begin
					put_utf8(rand_multibyte_cp(kind - 1));
				end
				6: begin
					append_byte(8'($urandom_range(255, 0)));
				end
				7: begin
					put_utf8(rand_multibyte_cp($urandom_range(4, 2)));
					void'(msg_q.pop_back());
				end
				default: begin
					put_utf8(rand_multibyte_cp($urandom_range(4, 2)));
					msg_q[msg_q.size()-1] = 8'($urandom_range(255, 0));
				end
			endcase
		end
	endtask

	task automatic test_extremes();
		msg_q = '{8'h00, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_message();
		settle();
	endtask

	// stray leads, second-byte limits, rescans, truncation at the end
	task automatic test_bad_sequences();
		msg_q = '{8'hC0, 8'hFF, 8'hE0, 8'h9F, 8'h80, 8'hED, 8'hA0, 8'h80,
			8'hF0, 8'h8F, 8'h80, 8'h80, 8'hF4, 8'h90};
		send_message();
		settle();
	endtask

	task automatic test_bom();
		cfg_write(1'b0);
		msg_q = '{8'hEF, 8'hBB, 8'hBF};
		send_message();
		settle();
		cfg_write(1'b1);
		send_message();
		settle();
	endtask

	task automatic test_random(input logic keep, input logic idle, input int target);
		int start;
		cfg_write(keep);
		tx_idle = idle;
		rx_idle = idle;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			build_random_message();
			send_message();
		end
		settle();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			unit_stall <= 1'b1;
		end else if (rx_idle && $urandom_range(5, 0) == 0) begin
			stall_left <= $urandom_range(13, 0);
			unit_stall <= 1'b1;
		end else begin
			unit_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		u8u16_pkg::unit_t want;
		if (arst_n && unit_valid && !unit_stall) begin
			if (unit_q.size() == 0) begin
				$error("unit %h with no transfer pending", unit_data);
				errors++;
			end else begin
				want = unit_q.pop_front();
				check_field("code_unit", int'(want.code_unit), int'(unit_data.code_unit));
				check_field("replaced", int'(want.replaced), int'(unit_data.replaced));
				check_field("run_last", int'(want.run_last), int'(unit_data.run_last));
				check_field("final_unit", int'(want.final_unit),
					int'(unit_data.final_unit));
				units_seen++;
				if (want.replaced) reps_seen++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		unit_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pend_cnt = 0;
		at_start = 1'b1;
		keep_bom_q = 1'b0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		stall_left = 0;
		errors = 0;
		bytes_sent = 0;
		msgs_sent = 0;
		units_seen = 0;
		reps_seen = 0;
		for (int k = 0; k < 3; k++) pend[k] = 8'h00;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_bad_sequences();
		test_bom();
		test_random(1'b0, 1'b1, 60);
		test_random(1'b1, 1'b1, 60);
		test_random(1'b0, 1'b0, 60);

		repeat (20) @(posedge clk);
		if (unit_q.size() != 0) begin
			$error("%0d expected units never arrived", unit_q.size());
			errors++;
		end
		$display("covered %0d bytes in %0d messages, %0d units checked, %0d replaced",
			bytes_sent, msgs_sent, units_seen, reps_seen);
		$display("keep_bom set both ways, random idling on both sides, then back-to-back");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
